/* rtl/core/tqac_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tqac_pkg
// shared types and codes of the tick quota admission controller
// ---------------------------------------------------------------------------
package tqac_pkg;

   // operation codes
   localparam logic [2:0] OP_START_TICK = 3'd0;
   localparam logic [2:0] OP_QUERY      = 3'd1;
   localparam logic [2:0] OP_OPEN       = 3'd2;
   localparam logic [2:0] OP_CLOSE      = 3'd3;
   localparam logic [2:0] OP_ADMIT      = 3'd4;
   localparam logic [2:0] OP_DEFER      = 3'd5;

   // status codes
   localparam logic [2:0] ST_OK           = 3'd0;
   localparam logic [2:0] ST_BAD_CONFIG   = 3'd1;
   localparam logic [2:0] ST_BUSY         = 3'd2;
   localparam logic [2:0] ST_BAD_CLIENT   = 3'd3;
   localparam logic [2:0] ST_NESTED       = 3'd4;
   localparam logic [2:0] ST_NOT_OPEN     = 3'd5;
   localparam logic [2:0] ST_BAD_DEFERRAL = 3'd6;

   // limit codes
   localparam logic [2:0] LIM_NONE       = 3'd0;
   localparam logic [2:0] LIM_GLOBAL_MSG = 3'd1;
   localparam logic [2:0] LIM_GLOBAL_BYT = 3'd2;
   localparam logic [2:0] LIM_GLOBAL_TIM = 3'd3;
   localparam logic [2:0] LIM_CLIENT_MSG = 3'd4;
   localparam logic [2:0] LIM_CLIENT_BYT = 3'd5;
   localparam logic [2:0] LIM_CLIENT_TIM = 3'd6;

   localparam int unsigned NUM_LIMITS = 6;

   // register indexes
   localparam logic [2:0] REG_GLOBAL_MSG = 3'd0;
   localparam logic [2:0] REG_GLOBAL_BYT = 3'd1;
   localparam logic [2:0] REG_GLOBAL_TIM = 3'd2;
   localparam logic [2:0] REG_CLIENT_MSG = 3'd3;
   localparam logic [2:0] REG_CLIENT_BYT = 3'd4;
   localparam logic [2:0] REG_CLIENT_TIM = 3'd5;

   localparam logic [15:0] RST_GLOBAL_MSG = 16'd1024;
   localparam logic [31:0] RST_GLOBAL_BYT = 32'd1048576;
   localparam logic [31:0] RST_GLOBAL_TIM = 32'd4000;
   localparam logic [15:0] RST_CLIENT_MSG = 16'd128;
   localparam logic [31:0] RST_CLIENT_BYT = 32'd65536;
   localparam logic [31:0] RST_CLIENT_TIM = 32'd1000;

   localparam int unsigned CSR_ADDR_BITS = 5;

   typedef struct packed {
      logic [15:0] global_msg;
      logic [31:0] global_byt;
      logic [31:0] global_tim;
      logic [15:0] client_msg;
      logic [31:0] client_byt;
      logic [31:0] client_tim;
   } cfg_type;

   typedef struct packed {
      logic capture;
      logic commit;
   } dp_cmd_type;

   typedef enum logic [0:0] {
      FSM_IDLE,
      FSM_EXEC
   } fsm_type;

endpackage
`default_nettype wire

/* rtl/core/tqac_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tqac_ram
// generic single write, single read ram with registered read
// ---------------------------------------------------------------------------
module tqac_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* rtl/core/tqac_regs.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tqac_regs
// limit registers behind the apb-style configuration port
// ---------------------------------------------------------------------------
module tqac_regs (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [tqac_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  wire logic [31:0]                          csr_pwdata,
   output logic      [31:0]                          csr_prdata,
   output logic                                      csr_pready,
   output tqac_pkg::cfg_type                         cfg
);
   import tqac_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_fire;
   logic [2:0] reg_idx;

   assign reg_idx    = csr_paddr[4:2];
   assign wr_fire    = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_fire) begin
         unique case (reg_idx)
            REG_GLOBAL_MSG: cfg_in.global_msg = csr_pwdata[15:0];
            REG_GLOBAL_BYT: cfg_in.global_byt = csr_pwdata;
            REG_GLOBAL_TIM: cfg_in.global_tim = csr_pwdata;
            REG_CLIENT_MSG: cfg_in.client_msg = csr_pwdata[15:0];
            REG_CLIENT_BYT: cfg_in.client_byt = csr_pwdata;
            REG_CLIENT_TIM: cfg_in.client_tim = csr_pwdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_GLOBAL_MSG: csr_prdata = {16'd0, cfg_ff.global_msg};
         REG_GLOBAL_BYT: csr_prdata = cfg_ff.global_byt;
         REG_GLOBAL_TIM: csr_prdata = cfg_ff.global_tim;
         REG_CLIENT_MSG: csr_prdata = {16'd0, cfg_ff.client_msg};
         REG_CLIENT_BYT: csr_prdata = cfg_ff.client_byt;
         REG_CLIENT_TIM: csr_prdata = cfg_ff.client_tim;
         default: csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.global_msg <= RST_GLOBAL_MSG;
         cfg_ff.global_byt <= RST_GLOBAL_BYT;
         cfg_ff.global_tim <= RST_GLOBAL_TIM;
         cfg_ff.client_msg <= RST_CLIENT_MSG;
         cfg_ff.client_byt <= RST_CLIENT_BYT;
         cfg_ff.client_tim <= RST_CLIENT_TIM;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

/* rtl/core/tqac_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tqac_ctrl
// request sequencer: capture, execute and result handshake
// ---------------------------------------------------------------------------
module tqac_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output tqac_pkg::dp_cmd_type  cmd
);
   import tqac_pkg::*;

   fsm_type state_ff;
   fsm_type state_in;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      unique case (state_ff)
         FSM_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            // wait for the result register to drain
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit = 1'b1;
               state_in   = FSM_IDLE;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTH
   a_capture_then_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> (state_ff == FSM_EXEC))
      else $error("capture not followed by execute");
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_ready))
      else $error("commit over an untaken result");
   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == FSM_EXEC))
      else $error("result raised outside execute");
`endif

endmodule
`default_nettype wire

/* rtl/core/tqac_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tqac_dp
// counters, client table and limit checks
// ---------------------------------------------------------------------------
module tqac_dp #(
   parameter int unsigned CLIENT_SLOTS = 256,
   parameter int unsigned COUNTER_BITS = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tqac_pkg::dp_cmd_type cmd,
   input  wire tqac_pkg::cfg_type    cfg,
   input  wire logic [2:0]           req_operation,
   input  wire logic [7:0]           req_client_id,
   input  wire logic [31:0]          req_tick_number,
   input  wire logic [31:0]          req_payload_bytes,
   input  wire logic [31:0]          req_time_us,
   input  wire logic [2:0]           req_limit_code,
   output logic      [2:0]           rsp_status,
   output logic                      rsp_admitted,
   output logic      [2:0]           rsp_limit_hit,
   output logic                      rsp_window_granted,
   output logic                      rsp_global_time_exhausted,
   output logic      [31:0]          rsp_global_overshoot_us
);
   import tqac_pkg::*;

   localparam int unsigned CB    = COUNTER_BITS;
   localparam int unsigned XW    = (COUNTER_BITS > 32) ? COUNTER_BITS : 32;
   localparam int unsigned IDX_W = $clog2(CLIENT_SLOTS);
   localparam int unsigned ROW_W = 3 * COUNTER_BITS;
   localparam logic [CB-1:0] CMAX = {CB{1'b1}};
   localparam logic [CB-1:0] ONE  = CB'(1);

   function automatic logic [CB-1:0] sat_add(input logic [CB-1:0] a, input logic [CB-1:0] b);
      logic [CB:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CB] ? CMAX : s[CB-1:0];
   endfunction

   function automatic logic [CB-1:0] to_cnt(input logic [31:0] v);
      logic [XW-1:0] e;
      e = XW'(v);
      return (e > XW'(CMAX)) ? CMAX : CB'(e);
   endfunction

   function automatic logic reached(input logic [CB-1:0] used, input logic [31:0] lim);
      return XW'(used) >= XW'(lim);
   endfunction

   function automatic logic exceeds(input logic [CB-1:0] used, input logic [31:0] amt,
                                    input logic [31:0] lim);
      logic [XW-1:0] u;
      logic [XW-1:0] l;
      logic [XW-1:0] a;
      u = XW'(used);
      l = XW'(lim);
      a = XW'(amt);
      return (u >= l) ? (a != '0) : (a > l - u);
   endfunction

   // captured request
   logic [2:0]       op_ff;
   logic [7:0]       id_ff;
   logic [31:0]      tick_in_ff;
   logic [31:0]      bytes_ff;
   logic [31:0]      time_ff;
   logic [2:0]       code_ff;

   // state
   logic [31:0]      tick_ff, tick_in;
   logic             window_ff, window_in;
   logic             exh_ff, exh_in;
   logic [CB-1:0]    g_cons_ff, g_cons_in;
   logic [CB-1:0]    g_amsg_ff, g_amsg_in;
   logic [CB-1:0]    g_abyte_ff, g_abyte_in;
   logic [CB-1:0]    g_def_ff, g_def_in;
   logic [CB-1:0]    g_stime_ff, g_stime_in;
   logic [CB-1:0]    g_sops_ff, g_sops_in;
   logic [CB-1:0]    g_smax_ff, g_smax_in;
   logic [CB-1:0]    g_over_ff, g_over_in;
   logic [CB-1:0]    g_atime_ff, g_atime_in;
   logic [CB-1:0]    g_defc_ff [NUM_LIMITS];
   logic [CB-1:0]    g_defc_in [NUM_LIMITS];
   logic [CLIENT_SLOTS-1:0] present_ff, present_in;

   // result
   logic [2:0]       status_ff, status_in;
   logic             admitted_ff, admitted_in;
   logic [2:0]       limit_ff, limit_in;
   logic             granted_ff, granted_in;

   // client row
   logic [IDX_W-1:0] idx;
   logic [ROW_W-1:0] rd_data;
   logic [ROW_W-1:0] wr_data;
   logic             row_wr;
   logic             row_hit;
   logic [CB-1:0]    c_amsg, c_abyte, c_atime;
   logic [CB-1:0]    c_amsg_n, c_abyte_n, c_atime_n;
   logic             id_ok;
   logic             cfg_bad;
   logic             def_fire;
   logic [2:0]       def_code;
   logic [CB-1:0]    t_cnt;
   logic [CB-1:0]    b_cnt;
   logic [XW-1:0]    stime_x;

   assign idx     = IDX_W'(id_ff);
   assign id_ok   = (id_ff != 8'd0) && ({24'd0, id_ff} < 32'(CLIENT_SLOTS));
   assign row_hit = present_ff[idx];
   assign c_amsg  = row_hit ? rd_data[3*CB-1:2*CB] : '0;
   assign c_abyte = row_hit ? rd_data[2*CB-1:CB] : '0;
   assign c_atime = row_hit ? rd_data[CB-1:0] : '0;
   assign wr_data = {c_amsg_n, c_abyte_n, c_atime_n};
   assign t_cnt   = to_cnt(time_ff);
   assign b_cnt   = to_cnt(bytes_ff);
   assign cfg_bad = (cfg.global_msg == 16'd0) || (cfg.global_byt == 32'd0) ||
                    (cfg.global_tim == 32'd0) || (cfg.client_msg == 16'd0) ||
                    (cfg.client_byt == 32'd0) || (cfg.client_tim == 32'd0);

   tqac_ram #(
      .WIDTH (ROW_W),
      .DEPTH (CLIENT_SLOTS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (cmd.commit && row_wr),
      .wr_addr (idx),
      .wr_data (wr_data),
      .rd_en   (cmd.capture),
      .rd_addr (IDX_W'(req_client_id)),
      .rd_data (rd_data)
   );

   always_comb begin
      tick_in    = tick_ff;
      window_in  = window_ff;
      exh_in     = exh_ff;
      g_cons_in  = g_cons_ff;
      g_amsg_in  = g_amsg_ff;
      g_abyte_in = g_abyte_ff;
      g_def_in   = g_def_ff;
      g_stime_in = g_stime_ff;
      g_sops_in  = g_sops_ff;
      g_smax_in  = g_smax_ff;
      g_over_in  = g_over_ff;
      g_atime_in = g_atime_ff;
      for (int k = 0; k < NUM_LIMITS; k++) begin
         g_defc_in[k] = g_defc_ff[k];
      end
      present_in  = present_ff;
      status_in   = ST_OK;
      admitted_in = 1'b0;
      limit_in    = LIM_NONE;
      granted_in  = 1'b0;
      row_wr      = 1'b0;
      c_amsg_n    = c_amsg;
      c_abyte_n   = c_abyte;
      c_atime_n   = c_atime;
      def_fire    = 1'b0;
      def_code    = LIM_NONE;
      stime_x     = '0;

      case (op_ff)
         OP_START_TICK: begin
            if (cfg_bad) begin
               status_in = ST_BAD_CONFIG;
            end else if (window_ff) begin
               status_in = ST_BUSY;
            end else begin
               window_in  = 1'b0;
               exh_in     = 1'b0;
               g_cons_in  = '0;
               g_amsg_in  = '0;
               g_abyte_in = '0;
               g_def_in   = '0;
               g_stime_in = '0;
               g_sops_in  = '0;
               g_smax_in  = '0;
               g_over_in  = '0;
               g_atime_in = '0;
               for (int k = 0; k < NUM_LIMITS; k++) begin
                  g_defc_in[k] = '0;
               end
               present_in = '0;
               tick_in    = tick_in_ff;
            end
         end
         OP_QUERY: begin
            if (!id_ok) begin
               status_in = ST_BAD_CLIENT;
            end else if (reached(g_amsg_ff, {16'd0, cfg.global_msg})) begin
               limit_in = LIM_GLOBAL_MSG;
            end else if (reached(g_abyte_ff, cfg.global_byt)) begin
               limit_in = LIM_GLOBAL_BYT;
            end else if (reached(g_stime_ff, cfg.global_tim)) begin
               limit_in = LIM_GLOBAL_TIM;
            end else if (row_hit) begin
               // client quotas only apply once the client was seen this tick
               if (reached(c_amsg, {16'd0, cfg.client_msg})) begin
                  limit_in = LIM_CLIENT_MSG;
               end else if (reached(c_abyte, cfg.client_byt)) begin
                  limit_in = LIM_CLIENT_BYT;
               end else if (reached(c_atime, cfg.client_tim)) begin
                  limit_in = LIM_CLIENT_TIM;
               end
            end
         end
         OP_OPEN: begin
            if (window_ff) begin
               status_in = ST_NESTED;
            end else if (reached(g_stime_ff, cfg.global_tim)) begin
               exh_in = 1'b1;
            end else begin
               window_in  = 1'b1;
               granted_in = 1'b1;
            end
         end
         OP_CLOSE: begin
            if (!window_ff) begin
               status_in = ST_NOT_OPEN;
            end else begin
               window_in  = 1'b0;
               g_sops_in  = sat_add(g_sops_ff, ONE);
               g_stime_in = sat_add(g_stime_ff, t_cnt);
               if (t_cnt > g_smax_ff) begin
                  g_smax_in = t_cnt;
               end
               stime_x   = XW'(g_stime_in);
               g_over_in = (stime_x > XW'(cfg.global_tim)) ?
                           CB'(stime_x - XW'(cfg.global_tim)) : '0;
               exh_in    = stime_x >= XW'(cfg.global_tim);
            end
         end
         OP_ADMIT: begin
            if (!id_ok) begin
               status_in = ST_BAD_CLIENT;
            end else if (window_ff) begin
               status_in = ST_BUSY;
            end else begin
               present_in[idx] = 1'b1;
               row_wr          = 1'b1;
               g_cons_in       = sat_add(g_cons_ff, ONE);
               if (reached(c_atime, cfg.client_tim)) begin
                  limit_in = LIM_CLIENT_TIM;
               end else begin
                  g_atime_in = sat_add(g_atime_ff, t_cnt);
                  c_atime_n  = sat_add(c_atime, t_cnt);
                  if (reached(g_amsg_ff, {16'd0, cfg.global_msg})) begin
                     limit_in = LIM_GLOBAL_MSG;
                  end else if (exceeds(g_abyte_ff, bytes_ff, cfg.global_byt)) begin
                     limit_in = LIM_GLOBAL_BYT;
                  end else if (reached(c_amsg, {16'd0, cfg.client_msg})) begin
                     limit_in = LIM_CLIENT_MSG;
                  end else if (exceeds(c_abyte, bytes_ff, cfg.client_byt)) begin
                     limit_in = LIM_CLIENT_BYT;
                  end else begin
                     g_amsg_in   = sat_add(g_amsg_ff, ONE);
                     g_abyte_in  = sat_add(g_abyte_ff, b_cnt);
                     c_amsg_n    = sat_add(c_amsg, ONE);
                     c_abyte_n   = sat_add(c_abyte, b_cnt);
                     admitted_in = 1'b1;
                  end
               end
               def_fire = (limit_in != LIM_NONE);
               def_code = limit_in;
            end
         end
         OP_DEFER: begin
            if (!id_ok) begin
               status_in = ST_BAD_CLIENT;
            end else if (code_ff == LIM_NONE || code_ff == 3'd7) begin
               status_in = ST_BAD_DEFERRAL;
            end else begin
               present_in[idx] = 1'b1;
               row_wr          = 1'b1;
               g_cons_in       = sat_add(g_cons_ff, ONE);
               def_fire        = 1'b1;
               def_code        = code_ff;
            end
         end
         default: status_in = ST_OK;
      endcase

      if (def_fire) begin
         g_def_in = sat_add(g_def_ff, ONE);
         for (int k = 0; k < NUM_LIMITS; k++) begin
            if (def_code == 3'(k + 1)) begin
               g_defc_in[k] = sat_add(g_defc_ff[k], ONE);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff      <= req_operation;
         id_ff      <= req_client_id;
         tick_in_ff <= req_tick_number;
         bytes_ff   <= req_payload_bytes;
         time_ff    <= req_time_us;
         code_ff    <= req_limit_code;
      end
      if (cmd.commit) begin
         status_ff   <= status_in;
         admitted_ff <= admitted_in;
         limit_ff    <= limit_in;
         granted_ff  <= granted_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff    <= '0;
         window_ff  <= 1'b0;
         exh_ff     <= 1'b0;
         g_cons_ff  <= '0;
         g_amsg_ff  <= '0;
         g_abyte_ff <= '0;
         g_def_ff   <= '0;
         g_stime_ff <= '0;
         g_sops_ff  <= '0;
         g_smax_ff  <= '0;
         g_over_ff  <= '0;
         g_atime_ff <= '0;
         for (int k = 0; k < NUM_LIMITS; k++) begin
            g_defc_ff[k] <= '0;
         end
         present_ff <= '0;
      end else if (cmd.commit) begin
         tick_ff    <= tick_in;
         window_ff  <= window_in;
         exh_ff     <= exh_in;
         g_cons_ff  <= g_cons_in;
         g_amsg_ff  <= g_amsg_in;
         g_abyte_ff <= g_abyte_in;
         g_def_ff   <= g_def_in;
         g_stime_ff <= g_stime_in;
         g_sops_ff  <= g_sops_in;
         g_smax_ff  <= g_smax_in;
         g_over_ff  <= g_over_in;
         g_atime_ff <= g_atime_in;
         for (int k = 0; k < NUM_LIMITS; k++) begin
            g_defc_ff[k] <= g_defc_in[k];
         end
         present_ff <= present_in;
      end
   end

   assign rsp_status                = status_ff;
   assign rsp_admitted              = admitted_ff;
   assign rsp_limit_hit             = limit_ff;
   assign rsp_window_granted        = granted_ff;
   assign rsp_global_time_exhausted = exh_ff;
   assign rsp_global_overshoot_us   = 32'(XW'(g_over_ff));

endmodule
`default_nettype wire

/* rtl/core/tick_quota_admission_control_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// sequencing: a request transfer captures the request and starts the table read, and the result
//   is registered by the execute state once the result register is free or being taken
// issue: a request is taken only in idle, because the table read precedes the update; a result
//   left waiting holds the next request in execute until it is taken
// reset: synchronous, clears counters, window, client presence and restores the limits
// ---------------------------------------------------------------------------
// tick_quota_admission_control_top
// per-tick admission controller with global and per-client quotas
// ---------------------------------------------------------------------------
module tick_quota_admission_control_top #(
   parameter int unsigned CLIENT_SLOTS = 256,
   parameter int unsigned COUNTER_BITS = 32
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request channel
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [2:0]                         req_operation,
   input  wire logic [7:0]                         req_client_id,
   input  wire logic [31:0]                        req_tick_number,
   input  wire logic [31:0]                        req_payload_bytes,
   input  wire logic [31:0]                        req_time_us,
   input  wire logic [2:0]                         req_limit_code,
   // result channel
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic      [2:0]                         rsp_status,
   output logic                                    rsp_admitted,
   output logic      [2:0]                         rsp_limit_hit,
   output logic                                    rsp_window_granted,
   output logic                                    rsp_global_time_exhausted,
   output logic      [31:0]                        rsp_global_overshoot_us,
   // configuration port
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [tqac_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [31:0]                        csr_pwdata,
   output logic      [31:0]                        csr_prdata,
   output logic                                    csr_pready
);
   import tqac_pkg::*;

   // limit registers shared by every check
   cfg_type    cfg;
   // sequencer commands toward the datapath
   dp_cmd_type cmd;

   // configuration registers, one transfer at a time; the user writes only while idle (unenforced)
   tqac_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // controller: idle takes the request and starts the table read,
   // execute commits state and loads the result register once it is free
   tqac_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // datapath: global counters in flops, client rows in the table ram
   tqac_dp #(
      .CLIENT_SLOTS (CLIENT_SLOTS),
      .COUNTER_BITS (COUNTER_BITS)
   ) u_dp (
      .clock                     (clock),
      .reset                     (reset),
      .cmd                       (cmd),
      .cfg                       (cfg),
      .req_operation             (req_operation),
      .req_client_id             (req_client_id),
      .req_tick_number           (req_tick_number),
      .req_payload_bytes         (req_payload_bytes),
      .req_time_us               (req_time_us),
      .req_limit_code            (req_limit_code),
      .rsp_status                (rsp_status),
      .rsp_admitted              (rsp_admitted),
      .rsp_limit_hit             (rsp_limit_hit),
      .rsp_window_granted        (rsp_window_granted),
      .rsp_global_time_exhausted (rsp_global_time_exhausted),
      .rsp_global_overshoot_us   (rsp_global_overshoot_us)
   );

endmodule
`default_nettype wire
